// ===== rtl/teabev_pkg.sv =====
package teabev_pkg;

  localparam int unsigned Rounds     = 32;
  localparam int unsigned ShiftLeft  = 4;
  localparam int unsigned ShiftRight = 5;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned InWidth    = 4 * DataWidth;
  localparam int unsigned OutWidth   = 72;
  localparam int unsigned OutPad     = OutWidth - 2 * DataWidth - 2;

  localparam logic [DataWidth-1:0] DeltaReset = 32'h9E37_79B9;

  typedef enum logic [2:0] {
    RegKey0      = 3'd0,
    RegKey1      = 3'd1,
    RegKey2      = 3'd2,
    RegKey3      = 3'd3,
    RegDelta     = 3'd4,
    RegKeyLoaded = 3'd5
  } reg_idx_e;

  typedef enum logic {
    FuncEncrypt = 1'b0,
    FuncVerify  = 1'b1
  } func_e;

  typedef struct packed {
    logic [DataWidth-1:0] key0;
    logic [DataWidth-1:0] key1;
    logic [DataWidth-1:0] key2;
    logic [DataWidth-1:0] key3;
    logic [DataWidth-1:0] delta;
    logic                 loaded;
  } cfg_t;

  // one pipeline slot: running halves plus what travels along for the compare
  typedef struct packed {
    func_e                func;
    logic [DataWidth-1:0] y;
    logic [DataWidth-1:0] z;
    logic [DataWidth-1:0] sum;
    logic [DataWidth-1:0] exp_high;
    logic [DataWidth-1:0] exp_low;
  } stage_t;

  // packed MSB first, so cipher_high lands in the lowest bits
  typedef struct packed {
    logic [OutPad-1:0]    pad;
    logic                 key_missing;
    logic                 match;
    logic [DataWidth-1:0] cipher_low;
    logic [DataWidth-1:0] cipher_high;
  } res_t;

  function automatic logic [DataWidth-1:0] tea_mix(
    input logic [DataWidth-1:0] v,
    input logic [DataWidth-1:0] sum,
    input logic [DataWidth-1:0] ka,
    input logic [DataWidth-1:0] kb
  );
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic [DataWidth-1:0] c;
    a = (v << ShiftLeft) + ka;
    b = v + sum;
    c = (v >> ShiftRight) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

// ===== rtl/teabev_cfg.sv =====
module teabev_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output teabev_pkg::cfg_t     cfg_o
);
  import teabev_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegKey0:      cfg_d.key0   = cfg_data_i;
        RegKey1:      cfg_d.key1   = cfg_data_i;
        RegKey2:      cfg_d.key2   = cfg_data_i;
        RegKey3:      cfg_d.key3   = cfg_data_i;
        RegDelta:     cfg_d.delta  = cfg_data_i;
        RegKeyLoaded: cfg_d.loaded = cfg_data_i[0];
        default:      cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key0   <= '0;
      cfg_q.key1   <= '0;
      cfg_q.key2   <= '0;
      cfg_q.key3   <= '0;
      cfg_q.delta  <= DeltaReset;
      cfg_q.loaded <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/teabev_round.sv =====
module teabev_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  teabev_pkg::stage_t   data_i,
  input  teabev_pkg::cfg_t     cfg_i,
  output logic                 valid_o,
  output teabev_pkg::stage_t   data_o
);
  import teabev_pkg::*;

  // first half updates y, second half updates z and steps the sum
  stage_t half_q, half_d;
  stage_t full_q, full_d;
  logic   half_valid_q, full_valid_q;

  always_comb begin
    half_d   = data_i;
    half_d.y = data_i.y + tea_mix(data_i.z, data_i.sum, cfg_i.key0, cfg_i.key1);
  end

  always_comb begin
    full_d     = half_q;
    full_d.z   = half_q.z + tea_mix(half_q.y, half_q.sum, cfg_i.key2, cfg_i.key3);
    full_d.sum = half_q.sum + cfg_i.delta;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_valid_q <= 1'b0;
      full_valid_q <= 1'b0;
    end else if (en_i) begin
      half_valid_q <= valid_i;
      full_valid_q <= half_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      half_q <= half_d;
      full_q <= full_d;
    end
  end

  assign valid_o = full_valid_q;
  assign data_o  = full_q;

endmodule

// ===== rtl/teabev_out.sv =====
module teabev_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  teabev_pkg::stage_t   data_i,
  input  teabev_pkg::cfg_t     cfg_i,
  output logic                 ready_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [71:0]          m_axis_tdata
);
  import teabev_pkg::*;

  res_t res;
  res_t out_q, out_d, skid_q, skid_d;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic in_acc;

  always_comb begin
    res     = '0;
    if (!cfg_i.loaded) begin
      res.key_missing = 1'b1;
    end else begin
      res.cipher_high = data_i.y;
      res.cipher_low  = data_i.z;
      res.match       = (data_i.func == FuncVerify) && (data_i.y == data_i.exp_high)
                        && (data_i.z == data_i.exp_low);
    end
  end

  assign ready_o = !skid_valid_q;
  assign in_acc  = valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || m_axis_tready) begin
      out_valid_d  = skid_valid_q || in_acc;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = 1'b0;
    end else if (in_acc) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid filled without an output stall");

  a_missing_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.key_missing) |->
      (out_q.cipher_high == '0 && out_q.cipher_low == '0 && !out_q.match))
    else $error("missing key result carries nonzero data");
`endif

endmodule

// ===== rtl/tea_block_encrypt_verify.sv =====
// TEA block encipher with optional compare against an expected ciphertext.
// Input stream: s_axis_tuser selects encrypt (0) or encrypt-and-verify (1);
// s_axis_tdata carries plaintext and expected words. One transaction in gives
// exactly one transaction out on m_axis, in order.
// Configuration: cfg_we_i/cfg_index_i/cfg_data_i write key words 0..3 (index
// 0..3), round delta (4) and key-loaded flag (5); write only while idle.
// Without a loaded key the result is all zero with key_missing set.
// Pipeline: each round is two register stages (y half, z half), and one output
// register follows the last round.
// Throughput: one block per cycle while m_axis_tready stays high.
// Stall: the output register plus a one-entry skid buffer absorb a stall;
// the pipeline freezes while the skid holds a result and s_axis_tready
// drops with it, so nothing is lost or repeated.
// Reset: pipeline and output valid bits clear; key words and loaded
// flag reset to zero, delta to 0x9E3779B9.
module tea_block_encrypt_verify (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] block_high, [63:32] block_low, [95:64] expected_high,
  // [127:96] expected_low
  input  logic [127:0] s_axis_tdata,
  // [0] func
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] cipher_high, [63:32] cipher_low, [64] match, [65] key_missing,
  // [71:66] zero
  output logic [71:0]  m_axis_tdata
);
  import teabev_pkg::*;

  cfg_t          cfg;
  stage_t        pipe_data  [Rounds+1];
  logic [Rounds:0] pipe_valid;
  logic          en;

  teabev_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s_axis_tready = en;
  assign pipe_valid[0] = s_axis_tvalid;

  always_comb begin
    pipe_data[0].func     = func_e'(s_axis_tuser[0]);
    pipe_data[0].y        = s_axis_tdata[DataWidth-1:0];
    pipe_data[0].z        = s_axis_tdata[2*DataWidth-1:DataWidth];
    pipe_data[0].exp_high = s_axis_tdata[3*DataWidth-1:2*DataWidth];
    pipe_data[0].exp_low  = s_axis_tdata[4*DataWidth-1:3*DataWidth];
    pipe_data[0].sum      = cfg.delta;
  end

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    teabev_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (pipe_valid[r]),
      .data_i  (pipe_data[r]),
      .cfg_i   (cfg),
      .valid_o (pipe_valid[r+1]),
      .data_o  (pipe_data[r+1])
    );
  end

  teabev_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (pipe_valid[Rounds]),
    .data_i        (pipe_data[Rounds]),
    .cfg_i         (cfg),
    .ready_o       (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== test/tea_block_encrypt_verify_tb.sv =====
`timescale 1ns / 100ps

module tea_block_encrypt_verify_tb;
  import teabev_pkg::*;

  typedef logic [DataWidth-1:0] word_t;

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned PipeLatency  = 2 * Rounds + 16;
  localparam int unsigned WatchdogMax  = 4000;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseBlocks  = 85;
  localparam int unsigned PrintMax     = 40;
  // register indexes with nothing behind them
  localparam logic [2:0]  IdxUnusedA   = 3'd6;
  localparam logic [2:0]  IdxUnusedB   = 3'd7;

  // Holds a private copy of the key registers and the ciphertexts still owed.
  class cipher_scoreboard;
    word_t       key_w[4];
    word_t       delta;
    bit          loaded;
    res_t        cipher_q[$];
    int unsigned errors;

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      delta  = DeltaReset;
      loaded = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, word_t data);
      case (idx)
        RegKey0:      key_w[0] = data;
        RegKey1:      key_w[1] = data;
        RegKey2:      key_w[2] = data;
        RegKey3:      key_w[3] = data;
        RegDelta:     delta    = data;
        RegKeyLoaded: loaded   = data[0];
        default: ;
      endcase
    endfunction

    function res_t encipher_block(func_e f, word_t bh, word_t bl, word_t eh, word_t el);
      res_t  r;
      word_t y;
      word_t z;
      word_t acc;
      r = '0;
      if (!loaded) begin
        r.key_missing = 1'b1;
        return r;
      end
      y   = bh;
      z   = bl;
      acc = '0;
      for (int i = 0; i < Rounds; i++) begin
        acc = acc + delta;
        y = y + (((z << ShiftLeft) + key_w[0]) ^ (z + acc) ^ ((z >> ShiftRight) + key_w[1]));
        z = z + (((y << ShiftLeft) + key_w[2]) ^ (y + acc) ^ ((y >> ShiftRight) + key_w[3]));
      end
      r.cipher_high = y;
      r.cipher_low  = z;
      r.match       = (f == FuncVerify) && (y == eh) && (z == el);
      return r;
    endfunction

    function void note_block(func_e f, word_t bh, word_t bl, word_t eh, word_t el);
      cipher_q.push_back(encipher_block(f, bh, bl, eh, el));
    endfunction

    function int unsigned pending();
      return cipher_q.size();
    endfunction

    task report(string msg);
      if (errors < PrintMax) $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [71:0] data);
      res_t got;
      res_t want;
      got = res_t'(data);
      if (cipher_q.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", data));
        return;
      end
      want = cipher_q.pop_front();
      if (got.cipher_high !== want.cipher_high)
        report($sformatf("cipher_high %h, want %h", got.cipher_high, want.cipher_high));
      if (got.cipher_low !== want.cipher_low)
        report($sformatf("cipher_low %h, want %h", got.cipher_low, want.cipher_low));
      if (got.match !== want.match)
        report($sformatf("match %b, want %b", got.match, want.match));
      if (got.key_missing !== want.key_missing)
        report($sformatf("key_missing %b, want %b", got.key_missing, want.key_missing));
      if (got.pad !== '0)
        report($sformatf("pad bits %b not zero", got.pad));
    endtask
  endclass

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [2:0]   cfg_index_i   = '0;
  logic [31:0]  cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  cipher_scoreboard sb = new();

  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned idle_cycles  = 0;

  tea_block_encrypt_verify u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // result side: ready in random stretches, with a stall in between as often as rx_stall_pct asks
  initial begin : sink_ready
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if ($urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogMax) begin
        $display("watchdog: no transaction for %0d cycles", WatchdogMax);
        $display("tea_block_encrypt_verify_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_block(func_e f, word_t bh, word_t bl, word_t eh, word_t el);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {el, eh, bl, bh};
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_block(f, bh, bl, eh, el);
  endtask

  // verify against the true ciphertext, optionally with some bits flipped
  task automatic send_check(word_t bh, word_t bl, word_t flip_h, word_t flip_l);
    res_t r;
    r = sb.encipher_block(FuncEncrypt, bh, bl, '0, '0);
    send_block(FuncVerify, bh, bl, r.cipher_high ^ flip_h, r.cipher_low ^ flip_l);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, word_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic load_config(word_t k0, word_t k1, word_t k2, word_t k3, word_t d,
                             word_t loaded_word);
    hold_until_drained();
    cfg_write(RegKey0, k0);
    cfg_write(RegKey1, k1);
    cfg_write(RegKey2, k2);
    cfg_write(RegKey3, k3);
    cfg_write(RegDelta, d);
    cfg_write(RegKeyLoaded, loaded_word);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random();
    word_t bh;
    word_t bl;
    word_t flip;
    int    kind;
    bh   = $urandom;
    bl   = $urandom;
    flip = word_t'(1) << $urandom_range(0, DataWidth - 1);
    kind = $urandom_range(0, 9);
    if (kind < 4)       send_block(FuncEncrypt, bh, bl, $urandom, $urandom);
    else if (kind < 7)  send_check(bh, bl, '0, '0);
    else if (kind == 7) begin
      if ($urandom_range(0, 1)) send_check(bh, bl, flip, '0);
      else                      send_check(bh, bl, '0, flip);
    end else            send_block(FuncVerify, bh, bl, $urandom, $urandom);
  endtask

  initial begin : stimulus
    res_t  r;
    word_t a;
    word_t b;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_gap_pct   = 30;
    rx_stall_pct = 30;

    // reset state: no key, every result zero with key_missing
    send_block(FuncEncrypt, '0, '0, '0, '0);
    send_block(FuncVerify, '1, '1, '1, '1);
    send_check('0, '0, '0, '0);

    load_config(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, DeltaReset, 1);
    send_block(FuncEncrypt, '0, '0, '0, '0);
    send_block(FuncEncrypt, '1, '1, '1, '1);
    send_block(FuncEncrypt, 32'h8000_0000, 32'h0000_0001, '0, '0);
    send_check('0, '0, '0, '0);
    send_check('1, '1, '0, '0);
    send_check($urandom, $urandom, 32'h0000_0001, '0);
    send_check($urandom, $urandom, '0, 32'h8000_0000);
    send_check($urandom, $urandom, '1, '1);
    // encrypt mode never flags a match, even with the right expected words
    a = $urandom;
    b = $urandom;
    r = sb.encipher_block(FuncEncrypt, a, b, '0, '0);
    send_block(FuncEncrypt, a, b, r.cipher_high, r.cipher_low);

    // writes to unmapped indexes must leave the key alone
    hold_until_drained();
    cfg_write(IdxUnusedA, $urandom);
    cfg_write(IdxUnusedB, $urandom);
    cfg_we_i <= 1'b0;
    send_check($urandom, $urandom, '0, '0);
    send_block(FuncEncrypt, $urandom, $urandom, $urandom, $urandom);

    // only bit 0 of the loaded flag counts
    hold_until_drained();
    cfg_write(RegKeyLoaded, 32'hFFFF_FFFE);
    cfg_we_i <= 1'b0;
    send_check($urandom, $urandom, '0, '0);
    send_block(FuncEncrypt, $urandom, $urandom, $urandom, $urandom);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: load_config('0, '0, '0, '0, '0, 1);
        1: load_config('1, '1, '1, '1, '1, '1);
        2: load_config($urandom, $urandom, $urandom, $urandom, DeltaReset, 1);
        3: load_config($urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFE);
        default: load_config($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom | 32'h1);
      endcase
      if (p == 0 || p == NumPhases - 1) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct   = $urandom_range(5, 60);
        rx_stall_pct = $urandom_range(5, 60);
      end
      repeat (PhaseBlocks) send_random();
    end

    hold_until_drained();
    repeat (PipeLatency) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tea_block_encrypt_verify_tb passed");
    end else begin
      $display("tea_block_encrypt_verify_tb failed");
    end
    $finish;
  end

endmodule
